[hdl/mre_pkg.sv]
// mre_pkg: opcodes, field codes and the decode result type shared by the
// minirv execute block. No dependencies.
`default_nettype none

package mre_pkg;

  localparam int DMEM_ADDR_BITS_DEF = 12;
  localparam int REG_COUNT = 16;
  localparam int REG_IDX_BITS = 4;

  localparam logic [6:0] OPC_IMM   = 7'b0010011;
  localparam logic [6:0] OPC_OP    = 7'b0110011;
  localparam logic [6:0] OPC_LUI   = 7'b0110111;
  localparam logic [6:0] OPC_STORE = 7'b0100011;
  localparam logic [6:0] OPC_JALR  = 7'b1100111;
  localparam logic [6:0] OPC_LOAD  = 7'b0000011;

  localparam logic [2:0] F3_BYTE  = 3'b000;
  localparam logic [2:0] F3_WORD  = 3'b010;
  localparam logic [2:0] F3_BYTEU = 3'b100;

  localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;
  localparam logic [31:0] JALR_MASK   = 32'hffff_fffe;

  localparam logic CMD_EXEC    = 1'b0;
  localparam logic CMD_PRELOAD = 1'b1;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_LW,
    MEM_LBU,
    MEM_SW,
    MEM_SB
  } mem_op_t;

  // decode and execute result of one instruction
  typedef struct packed {
    logic                    wr;
    logic [REG_IDX_BITS-1:0] rd;
    logic [31:0]             val;
    logic [31:0]             npc;
    logic                    halt_set;
    mem_op_t                 mem_op;
    logic [31:0]             addr;
  } ex_t;

  function automatic logic [31:0] sext12(input logic [11:0] v);
    sext12 = {{20{v[11]}}, v};
  endfunction

endpackage

`default_nettype wire

[hdl/minirv_instruction_execute.sv]
// minirv_instruction_execute: top level with pc, register file, data memory
// and the two pipeline stages. Depends on mre_pkg and mre_exec.
//
//  channel  dir  beat holds
//  s_axis   in   command (tuser), instr, preload_index, preload_data
//  m_axis   out  next_pc, halted, mem_addr, reg_written, reg_index, reg_value
//
// One item per clock while m_axis is not stalled; an input beat is registered
// in stage a, then in stage b, which drives m_axis_tvalid (stage a executes,
// stage b carries the data memory read).
// Load results are forwarded from stage b, so no stall for dependencies.
// rst clears pc, halt flag, last address and register valid bits; the data
// memory is not cleared. A stalled m_axis holds both stages; s_axis stays
// ready while stage a is empty.
`default_nettype none

module minirv_instruction_execute #(
  parameter int DMEM_ADDR_BITS = mre_pkg::DMEM_ADDR_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  // [31:0] instr, [43:32] preload_index, [75:44] preload_data, [79:76] zero
  input  wire logic [79:0]  s_axis_tdata,
  // [0] command
  input  wire logic         s_axis_tuser,
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [31:0] next_pc, [32] halted, [64:33] mem_addr, [65] reg_written,
  // [69:66] reg_index, [101:70] reg_value, [103:102] zero
  output      logic [103:0] m_axis_tdata
);
  import mre_pkg::*;

  localparam int DMEM_DEPTH = 1 << DMEM_ADDR_BITS;

  // architectural state
  logic [31:0]             pc;
  logic                    halted;
  logic [31:0]             last_addr;
  logic [31:0]             rf [REG_COUNT];
  logic [REG_COUNT-1:0]    rf_vld;
  logic [3:0][7:0]         dmem [DMEM_DEPTH];

  // stage a
  logic                    a_valid;
  logic                    a_cmd;
  logic [31:0]             a_instr;
  logic [11:0]             a_pidx;
  logic [31:0]             a_pdata;
  logic [31:0]             a_rs1;
  logic [31:0]             a_rs2;

  // stage b
  logic                    b_valid;
  logic [31:0]             b_npc;
  logic                    b_halted;
  logic [31:0]             b_addr;
  logic                    b_wr;
  logic [REG_IDX_BITS-1:0] b_idx;
  logic [31:0]             b_val;
  logic                    b_ld;
  logic                    b_byte;
  logic [1:0]              b_lane;
  logic [31:0]             b_rdata;
  logic [31:0]             b_ldval;
  logic [31:0]             b_result;

  logic                    adv;
  logic                    in_acc;
  logic                    a_fire;
  logic                    rf_wen;
  logic [REG_IDX_BITS-1:0] in_rs1;
  logic [REG_IDX_BITS-1:0] in_rs2;
  logic [REG_IDX_BITS-1:0] a_rs1_idx;
  logic [REG_IDX_BITS-1:0] a_rs2_idx;
  logic [31:0]             ex_rs1;
  logic [31:0]             ex_rs2;
  ex_t                     ex;

  logic                      mem_re;
  logic [3:0]                mem_we;
  logic [DMEM_ADDR_BITS-1:0] mem_idx;
  logic [3:0][7:0]           mem_wdata;

  logic [31:0]             pc_next;
  logic                    halted_next;
  logic [31:0]             last_addr_next;

  assign adv           = !b_valid || m_axis_tready;
  assign s_axis_tready = !a_valid || adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign a_fire        = a_valid && adv;
  assign rf_wen        = b_valid && adv && b_wr;

  assign in_rs1    = s_axis_tdata[18:15];
  assign in_rs2    = s_axis_tdata[23:20];
  assign a_rs1_idx = a_instr[18:15];
  assign a_rs2_idx = a_instr[23:20];

  // load data format
  always_comb begin
    unique case (b_lane)
      2'd0: b_ldval = {24'h0, b_rdata[7:0]};
      2'd1: b_ldval = {24'h0, b_rdata[15:8]};
      2'd2: b_ldval = {24'h0, b_rdata[23:16]};
      2'd3: b_ldval = {24'h0, b_rdata[31:24]};
      default: b_ldval = '0;
    endcase
    if (!b_wr) begin
      b_result = '0;
    end else if (b_ld) begin
      b_result = b_byte ? b_ldval : b_rdata;
    end else begin
      b_result = b_val;
    end
  end

  // stage b holds the previous instruction, still unwritten in the register file
  assign ex_rs1 = (b_valid && b_wr && b_idx == a_rs1_idx) ? b_result : a_rs1;
  assign ex_rs2 = (b_valid && b_wr && b_idx == a_rs2_idx) ? b_result : a_rs2;

  mre_exec u_exec (
    .instr   (a_instr),
    .pc      (pc),
    .rs1_val (ex_rs1),
    .rs2_val (ex_rs2),
    .halted  (halted),
    .ex      (ex)
  );

  // data memory access and state update for the item in stage a
  always_comb begin
    mem_re         = 1'b0;
    mem_we         = '0;
    mem_idx        = ex.addr[DMEM_ADDR_BITS+1:2];
    mem_wdata      = ex_rs2;
    pc_next        = pc;
    halted_next    = halted;
    last_addr_next = last_addr;
    if (a_cmd == CMD_PRELOAD) begin
      mem_idx   = DMEM_ADDR_BITS'(a_pidx);
      mem_wdata = a_pdata;
      mem_we    = {4{a_fire}};
    end else begin
      pc_next     = ex.npc;
      halted_next = halted || ex.halt_set;
      if (ex.mem_op != MEM_NONE) begin
        last_addr_next = ex.addr;
      end
      unique case (ex.mem_op)
        MEM_LW, MEM_LBU: mem_re = a_fire;
        MEM_SW:          mem_we = {4{a_fire}};
        MEM_SB: begin
          mem_wdata = {4{ex_rs2[7:0]}};
          mem_we    = a_fire ? (4'b0001 << ex.addr[1:0]) : 4'b0000;
        end
        MEM_NONE:        mem_re = 1'b0;
        default:         mem_re = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      if (mem_we[i]) begin
        dmem[mem_idx][i] <= mem_wdata[i];
      end
    end
    if (mem_re) begin
      b_rdata <= dmem[mem_idx];
    end
  end

  // register file, read as the beat is taken with bypass of a same-edge write
  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld <= '0;
    end else if (rf_wen) begin
      rf_vld[b_idx] <= 1'b1;
    end
    if (rf_wen) begin
      rf[b_idx] <= b_result;
    end
    if (in_acc) begin
      if (in_rs1 == '0) begin
        a_rs1 <= '0;
      end else if (rf_wen && b_idx == in_rs1) begin
        a_rs1 <= b_result;
      end else begin
        a_rs1 <= rf_vld[in_rs1] ? rf[in_rs1] : '0;
      end
      if (in_rs2 == '0) begin
        a_rs2 <= '0;
      end else if (rf_wen && b_idx == in_rs2) begin
        a_rs2 <= b_result;
      end else begin
        a_rs2 <= rf_vld[in_rs2] ? rf[in_rs2] : '0;
      end
    end
  end

  // stage a
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_axis_tready) begin
      a_valid <= s_axis_tvalid;
    end
    if (in_acc) begin
      a_cmd   <= s_axis_tuser;
      a_instr <= s_axis_tdata[31:0];
      a_pidx  <= s_axis_tdata[43:32];
      a_pdata <= s_axis_tdata[75:44];
    end
  end

  // architectural registers and stage b
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= '0;
      halted    <= 1'b0;
      last_addr <= '0;
      b_valid   <= 1'b0;
    end else begin
      if (adv) begin
        b_valid <= a_valid;
      end
      if (a_fire) begin
        pc        <= pc_next;
        halted    <= halted_next;
        last_addr <= last_addr_next;
      end
    end
    if (a_fire) begin
      b_npc    <= pc_next;
      b_halted <= halted_next;
      b_addr   <= last_addr_next;
      b_wr     <= (a_cmd == CMD_EXEC) && ex.wr;
      b_idx    <= (a_cmd == CMD_EXEC) ? ex.rd : '0;
      b_val    <= (a_cmd == CMD_EXEC) ? ex.val : '0;
      b_ld     <= (ex.mem_op == MEM_LW) || (ex.mem_op == MEM_LBU);
      b_byte   <= ex.mem_op == MEM_LBU;
      b_lane   <= ex.addr[1:0];
    end
  end

  assign m_axis_tvalid = b_valid;
  assign m_axis_tdata  = {2'b00, b_result, b_idx, b_wr, b_addr, b_halted, b_npc};

endmodule

`default_nettype wire

[hdl/mre_exec.sv]
// mre_exec: decode of one instruction word and its adds (alu, address, pc).
// Depends on mre_pkg.
`default_nettype none

module mre_exec (
  input  wire logic [31:0] instr,
  input  wire logic [31:0] pc,
  input  wire logic [31:0] rs1_val,
  input  wire logic [31:0] rs2_val,
  input  wire logic        halted,
  output mre_pkg::ex_t     ex
);
  import mre_pkg::*;

  logic [6:0]              opc;
  logic [2:0]              f3;
  logic [REG_IDX_BITS-1:0] rd;
  logic [31:0]             immi;
  logic [31:0]             imms;
  logic                    wr;
  logic [31:0]             val;

  assign opc  = instr[6:0];
  assign f3   = instr[14:12];
  assign rd   = instr[10:7];
  assign immi = sext12(instr[31:20]);
  assign imms = sext12({instr[31:25], instr[11:7]});

  always_comb begin
    wr          = 1'b0;
    val         = '0;
    ex.npc      = pc + 32'd4;
    ex.halt_set = 1'b0;
    ex.mem_op   = MEM_NONE;
    ex.addr     = '0;
    if (halted) begin
      ex.npc = pc;
    end else if (instr == EBREAK_WORD) begin
      ex.halt_set = 1'b1;
    end else if (opc == OPC_IMM && f3 == F3_BYTE) begin
      wr  = 1'b1;
      val = rs1_val + immi;
    end else if (opc == OPC_OP) begin
      wr  = 1'b1;
      val = rs1_val + rs2_val;
    end else if (opc == OPC_LUI) begin
      wr  = 1'b1;
      val = {instr[31:12], 12'h000};
    end else if (opc == OPC_STORE && (f3 == F3_BYTE || f3 == F3_WORD)) begin
      ex.addr   = rs1_val + imms;
      ex.mem_op = (f3 == F3_WORD) ? MEM_SW : MEM_SB;
    end else if (opc == OPC_JALR && f3 == F3_BYTE) begin
      wr     = 1'b1;
      val    = pc + 32'd4;
      ex.npc = (rs1_val + immi) & JALR_MASK;
    end else if (opc == OPC_LOAD && (f3 == F3_BYTEU || f3 == F3_WORD)) begin
      // value arrives from memory one stage later
      wr        = 1'b1;
      ex.addr   = rs1_val + immi;
      ex.mem_op = (f3 == F3_WORD) ? MEM_LW : MEM_LBU;
    end
    // writes to x0 are dropped
    ex.wr  = wr && (rd != '0);
    ex.rd  = ex.wr ? rd : '0;
    ex.val = ex.wr ? val : '0;
  end

endmodule

`default_nettype wire

[tb/testbench.sv]
// testbench for minirv_instruction_execute: random and directed instruction streams on s_axis,
// every m_axis beat checked against an in-bench model of the core state.
// Depends on mre_pkg and the minirv_instruction_execute RTL.
`default_nettype none

module testbench;
  import mre_pkg::*;

  localparam int AW = DMEM_ADDR_BITS_DEF;
  localparam int DMEM_WORDS = 1 << AW;
  localparam bit SIDE_PLAN = 1'b0;
  localparam bit SIDE_CHECK = 1'b1;
  localparam logic [2:0] F3_ADD = 3'b000;
  localparam logic [2:0] F3_JALR = 3'b000;
  localparam logic [2:0] F3_UNUSED = 3'b111;
  localparam int LONG_HOLD = 400;

  typedef struct packed {
    logic        command;
    logic [31:0] instr;
    logic [11:0] preload_index;
    logic [31:0] preload_data;
  } mre_item_t;

  // same bit order as m_axis_tdata[101:0]
  typedef struct packed {
    logic [31:0] reg_value;
    logic [3:0]  reg_index;
    logic        reg_written;
    logic [31:0] mem_addr;
    logic        halted;
    logic [31:0] next_pc;
  } exec_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [79:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;

  minirv_instruction_execute dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // two copies of the core state: one advanced while items are generated,
  // one advanced as beats are accepted
  logic [31:0] pc_q [2];
  logic        halt_q [2];
  logic [31:0] last_addr_q [2];
  logic [31:0] regs [2][REG_COUNT];
  logic [31:0] dmem [2][DMEM_WORDS];
  bit          written [2][DMEM_WORDS];

  mre_item_t    issue_queue [$];
  exec_result_t retired_results [$];
  int errors = 0;
  bit quiet = 1'b0;
  bit long_hold_due = 1'b0;

  function automatic logic [31:0] reg_of(input bit side, input logic [3:0] idx);
    return (idx == 4'd0) ? 32'd0 : regs[side][idx];
  endfunction

  task automatic retire_item(input bit side, input mre_item_t it, output exec_result_t res);
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [3:0]  rd;
    logic [31:0] a, b, immi, imms, npc, addr, wval, word;
    logic        wr;
    opc = it.instr[6:0];
    f3 = it.instr[14:12];
    rd = it.instr[10:7];
    a = reg_of(side, it.instr[18:15]);
    b = reg_of(side, it.instr[23:20]);
    immi = {{20{it.instr[31]}}, it.instr[31:20]};
    imms = {{20{it.instr[31]}}, it.instr[31:25], it.instr[11:7]};
    wr = 1'b0;
    wval = '0;
    if (it.command == CMD_PRELOAD) begin
      dmem[side][it.preload_index[AW-1:0]] = it.preload_data;
      written[side][it.preload_index[AW-1:0]] = 1'b1;
    end else if (!halt_q[side]) begin
      npc = pc_q[side] + 32'd4;
      if (it.instr == EBREAK_WORD) begin
        halt_q[side] = 1'b1;
      end else if (opc == OPC_IMM && f3 == F3_ADD) begin
        wr = 1'b1;
        wval = a + immi;
      end else if (opc == OPC_OP) begin
        wr = 1'b1;
        wval = a + b;
      end else if (opc == OPC_LUI) begin
        wr = 1'b1;
        wval = {it.instr[31:12], 12'd0};
      end else if (opc == OPC_STORE && (f3 == F3_BYTE || f3 == F3_WORD)) begin
        addr = a + imms;
        word = dmem[side][addr[AW+1:2]];
        if (f3 == F3_WORD) word = b;
        else word[addr[1:0]*8 +: 8] = b[7:0];
        dmem[side][addr[AW+1:2]] = word;
        written[side][addr[AW+1:2]] = 1'b1;
        last_addr_q[side] = addr;
      end else if (opc == OPC_JALR && f3 == F3_JALR) begin
        wr = 1'b1;
        wval = pc_q[side] + 32'd4;
        npc = (a + immi) & JALR_MASK;
      end else if (opc == OPC_LOAD && (f3 == F3_BYTEU || f3 == F3_WORD)) begin
        addr = a + immi;
        word = dmem[side][addr[AW+1:2]];
        wval = (f3 == F3_WORD) ? word : {24'd0, word[addr[1:0]*8 +: 8]};
        wr = 1'b1;
        last_addr_q[side] = addr;
      end
      if (wr && rd != 4'd0) regs[side][rd] = wval;
      else wr = 1'b0;
      pc_q[side] = npc;
    end
    res.next_pc = pc_q[side];
    res.halted = halt_q[side];
    res.mem_addr = last_addr_q[side];
    res.reg_written = wr;
    res.reg_index = wr ? rd : 4'd0;
    res.reg_value = wr ? wval : 32'd0;
  endtask

  function automatic logic [31:0] enc_i(input logic [6:0] opc, input logic [2:0] f3,
                                       input logic [4:0] rd, input logic [4:0] rs1,
                                       input logic [11:0] imm);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(input logic [2:0] f3, input logic [4:0] rs1,
                                       input logic [4:0] rs2, input logic [11:0] imm);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
  endfunction

  function automatic logic [31:0] enc_r(input logic [2:0] f3, input logic [6:0] f7,
                                       input logic [4:0] rd, input logic [4:0] rs1,
                                       input logic [4:0] rs2);
    return {f7, rs2, rs1, f3, rd, OPC_OP};
  endfunction

  function automatic mre_item_t exec_item(input logic [31:0] w);
    mre_item_t it;
    it.command = CMD_EXEC;
    it.instr = w;
    it.preload_index = 12'($urandom);
    it.preload_data = $urandom;
    return it;
  endfunction

  function automatic mre_item_t preload_item(input logic [11:0] idx, input logic [31:0] data);
    mre_item_t it;
    it.command = CMD_PRELOAD;
    it.instr = $urandom;
    it.preload_index = idx;
    it.preload_data = data;
    return it;
  endfunction

  task automatic queue_item(input mre_item_t it);
    exec_result_t unused;
    retire_item(SIDE_PLAN, it, unused);
    issue_queue.push_back(it);
  endtask

  // loads and byte stores read a word: pick a base and offset that land on a
  // word already written, falling back to x0 and finally to a word store
  task automatic queue_mem_op(input logic [2:0] f3, input bit is_store);
    logic [4:0]  rs1f, rdf;
    logic [11:0] imm;
    logic [31:0] addr;
    bit          ok;
    int          tries;
    rs1f = 5'($urandom);
    rdf = 5'($urandom);
    imm = '0;
    ok = 1'b0;
    tries = 0;
    while (!ok && tries < 48) begin
      if (tries == 8) rs1f = $urandom_range(0, 1) ? 5'd16 : 5'd0;
      imm = 12'($urandom);
      addr = reg_of(SIDE_PLAN, rs1f[3:0]) + {{20{imm[11]}}, imm};
      ok = (is_store && f3 == F3_WORD) || written[SIDE_PLAN][addr[AW+1:2]];
      tries++;
    end
    if (!ok) begin
      is_store = 1'b1;
      f3 = F3_WORD;
    end
    if (is_store) queue_item(exec_item(enc_s(f3, rs1f, rdf, imm)));
    else queue_item(exec_item(enc_i(OPC_LOAD, f3, rdf, rs1f, imm)));
  endtask

  task automatic queue_random();
    int pick;
    logic [31:0] w;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      queue_item(exec_item(enc_i(OPC_IMM, F3_ADD, 5'($urandom), 5'($urandom),
                                 12'($urandom))));
    end else if (pick < 22) begin
      queue_item(exec_item(enc_r(3'($urandom), 7'($urandom), 5'($urandom), 5'($urandom),
                                 5'($urandom))));
    end else if (pick < 30) begin
      w = $urandom;
      queue_item(exec_item({w[31:7], OPC_LUI}));
    end else if (pick < 42) begin
      queue_mem_op(F3_WORD, 1'b0);
    end else if (pick < 52) begin
      queue_mem_op(F3_BYTEU, 1'b0);
    end else if (pick < 62) begin
      queue_mem_op(F3_WORD, 1'b1);
    end else if (pick < 70) begin
      queue_mem_op(F3_BYTE, 1'b1);
    end else if (pick < 76) begin
      queue_item(exec_item(enc_i(OPC_JALR, F3_JALR, 5'($urandom), 5'($urandom),
                                 12'($urandom))));
    end else if (pick < 85) begin
      w = $urandom;
      // keep random words away from loads, stores and ebreak
      if (w[6:0] == OPC_LOAD || w[6:0] == OPC_STORE) w[14:12] = F3_UNUSED;
      if (w == EBREAK_WORD) w[31] = 1'b1;
      queue_item(exec_item(w));
    end else if ($urandom_range(0, 9) < 7) begin
      queue_item(preload_item(12'($urandom_range(0, 1) ? $urandom_range(0, 511)
                                                       : $urandom_range(3584, 4095)),
                              $urandom));
    end else begin
      queue_item(preload_item(12'($urandom), $urandom));
    end
  endtask

  // sender stays idle until every queued item has come back
  task automatic drain();
    while (issue_queue.size() != 0 || s_axis_tvalid || retired_results.size() != 0)
      @(negedge clk);
  endtask

  // driver
  mre_item_t on_bus;
  int        send_gap = 0;

  always @(posedge clk) begin : drive
    exec_result_t res;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        retire_item(SIDE_CHECK, on_bus, res);
        retired_results.push_back(res);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap == 0 && !quiet && $urandom_range(0, 9) == 0)
          send_gap = $urandom_range(1, 12);
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (issue_queue.size() != 0) begin
          on_bus = issue_queue.pop_front();
          s_axis_tdata <= {4'd0, on_bus.preload_data, on_bus.preload_index, on_bus.instr};
          s_axis_tuser <= on_bus.command;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  // monitor and result-side flow control
  int  stall_count = 0;
  int  hold_count = 0;
  bit  long_hold_done = 1'b0;

  always @(posedge clk) begin : receive
    exec_result_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[101:0];
        if (retired_results.size() == 0) begin
          $error("result beat with nothing outstanding: %h", m_axis_tdata);
          errors++;
        end else begin
          want = retired_results.pop_front();
          check_field("next_pc", want.next_pc, got.next_pc);
          check_field("halted", 32'(want.halted), 32'(got.halted));
          check_field("mem_addr", want.mem_addr, got.mem_addr);
          check_field("reg_written", 32'(want.reg_written), 32'(got.reg_written));
          check_field("reg_index", 32'(want.reg_index), 32'(got.reg_index));
          check_field("reg_value", want.reg_value, got.reg_value);
        end
      end
      if (long_hold_due && !long_hold_done) begin
        hold_count = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (hold_count > 0) begin
        hold_count--;
        m_axis_tready <= 1'b0;
      end else if (stall_count > 0) begin
        stall_count--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_count = $urandom_range(1, 12) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    for (int s = 0; s < 2; s++) begin
      pc_q[s] = '0;
      halt_q[s] = 1'b0;
      last_addr_q[s] = '0;
      for (int r = 0; r < REG_COUNT; r++) regs[s][r] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, every operation, index and address wrap
    queue_item(preload_item(12'd0, 32'hffff_ffff));
    queue_item(preload_item(12'hfff, 32'h8000_0001));
    queue_item(preload_item(12'd1, 32'h1234_5678));
    queue_item(exec_item({20'hfffff, 5'd1, OPC_LUI}));
    queue_item(exec_item(enc_i(OPC_IMM, F3_ADD, 5'd2, 5'd0, 12'h7ff)));
    queue_item(exec_item(enc_i(OPC_IMM, F3_ADD, 5'd3, 5'd0, 12'h800)));
    queue_item(exec_item(enc_r(3'b111, 7'h7f, 5'd4, 5'd1, 5'd2)));
    // write to x0 is dropped
    queue_item(exec_item(enc_i(OPC_IMM, F3_ADD, 5'd0, 5'd1, 12'd5)));
    // upper index bit ignored: rd 31 -> x15, rs1 18 -> x2
    queue_item(exec_item(enc_i(OPC_IMM, F3_ADD, 5'd31, 5'd18, 12'd1)));
    queue_item(exec_item(enc_i(OPC_LOAD, F3_WORD, 5'd5, 5'd0, 12'd4)));
    queue_item(exec_item(enc_i(OPC_LOAD, F3_BYTEU, 5'd6, 5'd0, 12'd3)));
    queue_item(exec_item(enc_i(OPC_LOAD, F3_BYTEU, 5'd7, 5'd0, 12'd5)));
    // negative address wraps to the top word
    queue_item(exec_item(enc_i(OPC_LOAD, F3_WORD, 5'd8, 5'd0, 12'hffc)));
    queue_item(exec_item(enc_s(F3_WORD, 5'd0, 5'd1, 12'd8)));
    queue_item(exec_item(enc_s(F3_BYTE, 5'd0, 5'd2, 12'd9)));
    queue_item(exec_item(enc_i(OPC_LOAD, F3_WORD, 5'd9, 5'd0, 12'd8)));
    queue_item(exec_item(enc_s(F3_BYTE, 5'd0, 5'd2, 12'hfff)));
    // known opcodes with unused funct3 only advance the pc
    queue_item(exec_item(enc_i(OPC_LOAD, 3'b000, 5'd10, 5'd0, 12'd0)));
    queue_item(exec_item(enc_s(3'b001, 5'd0, 5'd1, 12'd0)));
    queue_item(exec_item(enc_i(OPC_JALR, 3'b001, 5'd10, 5'd1, 12'd0)));
    queue_item(exec_item(32'hffff_ffff));
    queue_item(exec_item(enc_i(OPC_JALR, F3_JALR, 5'd10, 5'd2, 12'd1)));
    // odd target has bit 0 cleared
    queue_item(exec_item(enc_i(OPC_JALR, F3_JALR, 5'd11, 5'd2, 12'd0)));
    queue_item(exec_item(enc_i(OPC_JALR, F3_JALR, 5'd0, 5'd1, 12'hfff)));
    // pc near the top, the next step wraps
    queue_item(exec_item(enc_i(OPC_JALR, F3_JALR, 5'd12, 5'd0, 12'hffe)));
    drain();

    // random with a long result-side hold at the start
    long_hold_due = 1'b1;
    repeat (600) queue_random();
    drain();

    repeat (700) queue_random();
    drain();

    // last stretch without idling, ending in ebreak and items while halted
    quiet = 1'b1;
    repeat (350) queue_random();
    queue_item(exec_item(EBREAK_WORD));
    queue_item(exec_item(enc_i(OPC_IMM, F3_ADD, 5'd1, 5'd1, 12'd1)));
    queue_item(preload_item(12'($urandom), $urandom));
    queue_item(exec_item(enc_i(OPC_JALR, F3_JALR, 5'd2, 5'd3, 12'd0)));
    queue_item(exec_item(EBREAK_WORD));
    queue_item(preload_item(12'($urandom), $urandom));
    drain();
    repeat (8) @(posedge clk);

    if (errors == 0 && retired_results.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
hdl/mre_pkg.sv
hdl/mre_exec.sv
hdl/minirv_instruction_execute.sv
tb/testbench.sv
